/* rtl/tsq_pkg.sv */
// tsq_pkg: shared types, sizes and operation codes of the time-stamped sample queue
// used by the channel interfaces, the queue cell and the top level
package tsq_pkg;

    localparam int DEPTH    = 16;
    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int SPAN_W   = 36;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OP_W     = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // one queued sample
    typedef struct packed {
        logic [TIME_W-1:0]   start;
        logic [TIME_W-1:0]   stop;
        logic [HANDLE_W-1:0] handle;
    } sample_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic wr;    // load the incoming sample
        logic adv;   // take a word from the neighbor
        logic wrap;  // take the head word instead (rotation tail)
    } cell_ctl_t;

    // duration of an interval, zero when reversed
    function automatic logic [TIME_W-1:0] span_dur(input logic [TIME_W-1:0] s,
                                                   input logic [TIME_W-1:0] e);
        logic [TIME_W-1:0] d;
        begin
            d = (e >= s) ? (e - s) : '0;
            return d;
        end
    endfunction

endpackage

/* rtl/tsq_ifs.sv */
// tsq_cmd_if and tsq_res_if: valid/ready channels of the sample queue
// depends on tsq_pkg for field widths
interface tsq_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [tsq_pkg::OP_W-1:0]        op;
    logic [tsq_pkg::TIME_W-1:0]      new_start;
    logic [tsq_pkg::TIME_W-1:0]      new_stop;
    logic [tsq_pkg::HANDLE_W-1:0]    new_handle;
    logic [tsq_pkg::TIME_W-1:0]      target_time;

    modport source (output valid, op, new_start, new_stop, new_handle, target_time,
                    input ready);
    modport sink (input valid, op, new_start, new_stop, new_handle, target_time,
                  output ready);
endinterface

interface tsq_res_if;
    logic                            valid;
    logic                            ready;
    logic                            has_sample;
    logic [tsq_pkg::TIME_W-1:0]      out_start;
    logic [tsq_pkg::TIME_W-1:0]      out_stop;
    logic [tsq_pkg::HANDLE_W-1:0]    out_handle;
    logic                            last;
    logic                            push_dropped;
    logic [tsq_pkg::TIME_W-1:0]      front_time;
    logic [tsq_pkg::SPAN_W-1:0]      total_span;
    logic [tsq_pkg::CNT_W-1:0]       held_count;

    modport source (output valid, has_sample, out_start, out_stop, out_handle, last,
                    push_dropped, front_time, total_span, held_count,
                    input ready);
    modport sink (input valid, has_sample, out_start, out_stop, out_handle, last,
                  push_dropped, front_time, total_span, held_count,
                  output ready);
endinterface

/* rtl/tsq_cell.sv */
// tsq_cell: one storage cell of the sample row
// loads a pushed sample or takes the word of its neighbor or of the head; uses tsq_pkg
module tsq_cell (
    input  logic               clk,
    input  tsq_pkg::cell_ctl_t ctl,
    input  tsq_pkg::sample_t   wr_data,
    input  tsq_pkg::sample_t   neighbor,
    input  tsq_pkg::sample_t   head,
    output tsq_pkg::sample_t   data
);
    import tsq_pkg::*;

    sample_t data_reg;

    // sample storage, no reset: only occupied cells are read
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            data_reg <= wr_data;
        end
        else if (ctl.adv)
        begin
            if (ctl.wrap)
            begin
                data_reg <= head;
            end
            else
            begin
                data_reg <= neighbor;
            end
        end
    end

    assign data = data_reg;

endmodule

/* rtl/timestamp_sample_queue.sv */
// Time-stamped sample queue, top level: a row of DEPTH cells with the front sample in
// cell 0, plus the sequencer that pushes, scans, pops and reports. Push, clear, op 3
// and a pop on an empty queue or with a target before the front time give one status
// word; a pop that scans the row and finds no match gives its status word after the
// scan. A matching pop first rotates the queued samples once through cell 0 to find
// the match and sum the popped durations, updates count, span and front time in
// ST_FIN, then shifts out one popped sample per cycle while the result register
// drains. One command is handled at a time; the next is taken once the last word of
// the previous one sits in the result register.
module timestamp_sample_queue (
    input  logic      clk,
    input  logic      rst_n,
    tsq_cmd_if.sink   cmd,
    tsq_res_if.source res
);
    import tsq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0]          state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [TIME_W-1:0]   begin_reg;
    logic                drop_reg;
    logic                matched_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic [CNT_W-1:0]    found_reg;
    logic [CNT_W-1:0]    emit_reg;
    logic [TIME_W-1:0]   tgt_reg;
    logic [SPAN_W-1:0]   acc_reg;
    logic [TIME_W-1:0]   front_new_reg;

    logic                res_valid_reg;
    logic                res_has_reg;
    sample_t             res_sample_reg;
    logic                res_last_reg;
    logic                res_drop_reg;
    logic [TIME_W-1:0]   res_front_reg;
    logic [SPAN_W-1:0]   res_span_reg;
    logic [CNT_W-1:0]    res_count_reg;

    sample_t             cell_q   [DEPTH];
    sample_t             nbr      [DEPTH];
    cell_ctl_t           cell_ctl [DEPTH];

    logic                cmd_fire;
    logic                out_free;
    logic                full;
    logic                push_ok;
    logic                scan_adv;
    logic                emit_adv;
    logic                load_status;
    logic                emit_last;
    logic                pop_go;
    logic [CNT_W-1:0]    tail_idx;
    sample_t             head;
    sample_t             new_sample;
    logic [TIME_W-1:0]   head_dur;
    logic                head_hit;

    // handshake and phase strobes
    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign out_free    = !res_valid_reg || res.ready;
    assign full        = (count_reg == CNT_W'(DEPTH));
    assign push_ok     = cmd_fire && (cmd.op == OP_PUSH) && !full;
    assign pop_go      = (count_reg != '0) && (cmd.target_time >= begin_reg);
    assign scan_adv    = (state_reg == ST_SCAN);
    assign emit_adv    = (state_reg == ST_EMIT) && out_free;
    assign load_status = (state_reg == ST_RESP) && out_free;
    assign tail_idx    = count_reg - CNT_W'(1);
    assign emit_last   = (emit_reg == found_reg - CNT_W'(1));

    // head cell checks against the pop target
    assign head     = cell_q[0];
    assign head_dur = span_dur(head.start, head.stop);
    assign head_hit = ((head.start == head.stop) && (head.start == tgt_reg)) ||
                      ((head.start <= tgt_reg) && (tgt_reg < head.stop));

    assign new_sample = '{start: cmd.new_start, stop: cmd.new_stop,
                          handle: cmd.new_handle};

    // row of cells, the last one closes the ring through the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_end
            assign nbr[i] = cell_q[0];
        end
        else
        begin : g_mid
            assign nbr[i] = cell_q[i+1];
        end

        assign cell_ctl[i].wr   = push_ok && (count_reg == CNT_W'(i));
        assign cell_ctl[i].adv  = scan_adv || emit_adv;
        assign cell_ctl[i].wrap = scan_adv && (tail_idx == CNT_W'(i));

        tsq_cell u_cell (
            .clk      (clk),
            .ctl      (cell_ctl[i]),
            .wr_data  (new_sample),
            .neighbor (nbr[i]),
            .head     (head),
            .data     (cell_q[i])
        );
    end

    // sequencer and queue bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            span_reg      <= '0;
            begin_reg     <= '0;
            drop_reg      <= 1'b0;
            matched_reg   <= 1'b0;
            scan_reg      <= '0;
            found_reg     <= '0;
            emit_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // result register occupancy
            if (emit_adv || load_status)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        drop_reg  <= (cmd.op == OP_PUSH) && full;
                        state_reg <= ((cmd.op == OP_POP) && pop_go) ? ST_SCAN : ST_RESP;
                        unique case (cmd.op)
                            OP_PUSH:
                            begin
                                if (!full)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                    span_reg  <= span_reg +
                                                 SPAN_W'(span_dur(cmd.new_start, cmd.new_stop));
                                    if (count_reg == '0)
                                    begin
                                        begin_reg <= cmd.new_start;
                                    end
                                end
                            end
                            OP_POP:
                            begin
                                if (pop_go)
                                begin
                                    matched_reg <= 1'b0;
                                    scan_reg    <= '0;
                                end
                            end
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                span_reg  <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (!matched_reg && head_hit)
                    begin
                        matched_reg <= 1'b1;
                        found_reg   <= scan_reg + CNT_W'(1);
                    end
                    scan_reg <= scan_reg + CNT_W'(1);
                    if (scan_reg == tail_idx)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (matched_reg)
                    begin
                        count_reg <= count_reg - found_reg;
                        span_reg  <= span_reg - acc_reg;
                        if (count_reg != found_reg)
                        begin
                            begin_reg <= front_new_reg;
                        end
                        emit_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        emit_reg <= emit_reg + CNT_W'(1);
                        if (emit_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // scan accumulators and result word
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            tgt_reg <= cmd.target_time;
            acc_reg <= '0;
        end
        else if (scan_adv && !matched_reg)
        begin
            acc_reg <= acc_reg + SPAN_W'(head_dur);
        end

        // start of the sample right after the match is the new front
        if (scan_adv && matched_reg && (scan_reg == found_reg))
        begin
            front_new_reg <= head.start;
        end

        if (emit_adv)
        begin
            res_has_reg    <= 1'b1;
            res_sample_reg <= head;
            res_last_reg   <= emit_last;
            res_drop_reg   <= 1'b0;
            res_front_reg  <= begin_reg;
            res_span_reg   <= span_reg;
            res_count_reg  <= count_reg;
        end
        else if (load_status)
        begin
            res_has_reg    <= 1'b0;
            res_sample_reg <= '0;
            res_last_reg   <= 1'b1;
            res_drop_reg   <= drop_reg;
            res_front_reg  <= begin_reg;
            res_span_reg   <= span_reg;
            res_count_reg  <= count_reg;
        end
    end

    // result channel
    assign res.valid        = res_valid_reg;
    assign res.has_sample   = res_has_reg;
    assign res.out_start    = res_sample_reg.start;
    assign res.out_stop     = res_sample_reg.stop;
    assign res.out_handle   = res_sample_reg.handle;
    assign res.last         = res_last_reg;
    assign res.push_dropped = res_drop_reg;
    assign res.front_time   = res_front_reg;
    assign res.total_span   = res_span_reg;
    assign res.held_count   = res_count_reg;

endmodule
